/* design/rvc_pkg.sv */
package rvc_pkg;

  // number format of the controlled value
  localparam int unsigned VALUE_WIDTH   = 32;
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned STEP_WIDTH    = VALUE_WIDTH - 1;

  // damping multiplier, unsigned q1.16
  localparam int unsigned DAMP_BITS  = 16;
  localparam int unsigned DAMP_WIDTH = DAMP_BITS + 1;
  localparam logic [DAMP_WIDTH-1:0] DAMP_ONE   = DAMP_WIDTH'(1 << DAMP_BITS);
  localparam logic [DAMP_WIDTH-1:0] DAMP_RESET = DAMP_WIDTH'(62259);

  // register reset values
  localparam logic signed [VALUE_WIDTH-1:0] UPPER_RESET = VALUE_WIDTH'(1 << FRACTION_BITS);
  localparam logic signed [VALUE_WIDTH-1:0] LOWER_RESET = -UPPER_RESET;
  localparam logic [STEP_WIDTH-1:0] STEP_RESET =
    STEP_WIDTH'(((1 << FRACTION_BITS) + 10) / 20);

  // configuration bus
  localparam int unsigned DATA_WIDTH    = (VALUE_WIDTH > 32) ? 64 : 32;
  localparam int unsigned ADDR_LSB      = (VALUE_WIDTH > 32) ? 3 : 2;
  localparam int unsigned REG_IDX_WIDTH = 3;
  localparam int unsigned ADDR_WIDTH    = REG_IDX_WIDTH + ADDR_LSB;

  // stream payload widths
  localparam int unsigned IN_TDATA_WIDTH  = 8;
  localparam int unsigned IN_TUSER_WIDTH  = 2;
  localparam int unsigned OUT_FIELD_BITS  = VALUE_WIDTH + 4;
  localparam int unsigned OUT_TDATA_WIDTH = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_LESS = 2'd1,
    OP_MORE = 2'd2,
    OP_STOP = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_PLUS  = 2'd1,
    DIR_MINUS = 2'd2
  } dir_e;

  typedef struct packed {
    logic [DAMP_WIDTH-1:0]         damp;
    logic signed [VALUE_WIDTH-1:0] upper;
    logic signed [VALUE_WIDTH-1:0] lower;
    logic [STEP_WIDTH-1:0]         step;
    logic                          linear;
    logic                          multiply;
  } cfg_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] level;
    dir_e                          dir;
    logic                          more;
    logic                          less;
    logic                          stop;
    logic                          active;
  } state_t;

endpackage

/* design/ramped_value_controller.sv */
// Ramped value controller: each input item is a tick or a press/release of
// the less, more or stop button, and each one yields exactly one result item
// with the level (signed Q16.16) and the active and held flags after it.
// An item is captured in an input register and its result lands in the
// output register once that register is free, so throughput is one item
// per cycle while the output is not stalled; the path between the two
// registers (ramp add, limit clamp, one 32x17 damping multiply) sets the
// clock rate. Limits, step and damping come from the register port and
// are meant to be written while no item is in flight.
module ramped_value_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input items
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [rvc_pkg::IN_TDATA_WIDTH-1:0]  s_axis_tdata,  // [0] pressed
  input  logic [rvc_pkg::IN_TUSER_WIDTH-1:0]  s_axis_tuser,  // [1:0] operation
  // result items
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [31:0] level, [32] is_active, [33] more_held, [34] less_held, [35] stop_held
  output logic [rvc_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rvc_pkg::ADDR_WIDTH-1:0]      paddr,
  input  logic [rvc_pkg::DATA_WIDTH-1:0]      pwdata,
  output logic [rvc_pkg::DATA_WIDTH-1:0]      prdata,
  output logic                                pready
);
  import rvc_pkg::*;

  cfg_t   cfg;
  state_t state_q, state_d;
  logic   in_valid_q, in_pressed_q, out_valid_q, advance;
  op_e    in_op_q;
  logic [OUT_TDATA_WIDTH-1:0] out_data_q;

  rvc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rvc_step u_step (
    .cfg_i     (cfg),
    .state_i   (state_q),
    .op_i      (in_op_q),
    .pressed_i (in_pressed_q),
    .state_o   (state_d)
  );

  // handshake: the held item moves on whenever the output register frees up
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q      <= op_e'(s_axis_tuser[1:0]);
      in_pressed_q <= s_axis_tdata[0];
    end
  end

  // controller state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.level  <= '0;
      state_q.dir    <= DIR_NONE;
      state_q.more   <= 1'b0;
      state_q.less   <= 1'b0;
      state_q.stop   <= 1'b0;
      state_q.active <= 1'b0;
      out_valid_q    <= 1'b0;
    end else if (advance) begin
      state_q     <= state_d;
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= OUT_TDATA_WIDTH'({state_d.stop, state_d.less, state_d.more,
                                      state_d.active, state_d.level});
    end
  end

endmodule

/* design/rvc_regs.sv */
module rvc_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rvc_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [rvc_pkg::DATA_WIDTH-1:0] pwdata,
  output logic [rvc_pkg::DATA_WIDTH-1:0] prdata,
  output logic                           pready,
  output rvc_pkg::cfg_t                  cfg_o
);
  import rvc_pkg::*;

  typedef enum logic [REG_IDX_WIDTH-1:0] {
    REG_DAMP     = 3'd0,
    REG_UPPER    = 3'd1,
    REG_LOWER    = 3'd2,
    REG_STEP     = 3'd3,
    REG_LINEAR   = 3'd4,
    REG_MULTIPLY = 3'd5
  } reg_idx_e;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_LSB +: REG_IDX_WIDTH]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.damp     <= DAMP_RESET;
      cfg_q.upper    <= UPPER_RESET;
      cfg_q.lower    <= LOWER_RESET;
      cfg_q.step     <= STEP_RESET;
      cfg_q.linear   <= 1'b0;
      cfg_q.multiply <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        REG_DAMP:     cfg_q.damp     <= pwdata[DAMP_WIDTH-1:0];
        REG_UPPER:    cfg_q.upper    <= pwdata[VALUE_WIDTH-1:0];
        REG_LOWER:    cfg_q.lower    <= pwdata[VALUE_WIDTH-1:0];
        REG_STEP:     cfg_q.step     <= pwdata[STEP_WIDTH-1:0];
        REG_LINEAR:   cfg_q.linear   <= pwdata[0];
        REG_MULTIPLY: cfg_q.multiply <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_DAMP:     prdata = DATA_WIDTH'(cfg_q.damp);
      REG_UPPER:    prdata = DATA_WIDTH'(unsigned'(cfg_q.upper));
      REG_LOWER:    prdata = DATA_WIDTH'(unsigned'(cfg_q.lower));
      REG_STEP:     prdata = DATA_WIDTH'(cfg_q.step);
      REG_LINEAR:   prdata = DATA_WIDTH'(cfg_q.linear);
      REG_MULTIPLY: prdata = DATA_WIDTH'(cfg_q.multiply);
      default:      prdata = '0;
    endcase
  end

endmodule

/* design/rvc_step.sv */
module rvc_step (
  input  rvc_pkg::cfg_t   cfg_i,
  input  rvc_pkg::state_t state_i,
  input  rvc_pkg::op_e    op_i,
  input  logic            pressed_i,
  output rvc_pkg::state_t state_o
);
  import rvc_pkg::*;

  localparam int unsigned SW = VALUE_WIDTH + 1;
  localparam int unsigned PW = VALUE_WIDTH + DAMP_WIDTH;

  logic signed [SW-1:0]          lvl_x, step_x, nstep_x, delta_x, sum_x;
  logic signed [SW-1:0]          up_x, lo_x, clamp_x, tick_x, lin_x;
  logic signed [VALUE_WIDTH-1:0] ticked, mul_sgn, mul_res, lin_res, damped;
  logic [DAMP_WIDTH-1:0]         damp_eff;
  logic [VALUE_WIDTH-1:0]        mag, scaled;
  logic [PW-1:0]                 prod;

  // ramp add and clamp, in one extra bit so the sum cannot wrap
  assign lvl_x   = SW'(state_i.level);
  assign step_x  = $signed({2'b00, cfg_i.step});
  assign nstep_x = -step_x;
  assign up_x    = SW'(cfg_i.upper);
  assign lo_x    = SW'(cfg_i.lower);

  always_comb begin
    case (state_i.dir)
      DIR_PLUS:  delta_x = step_x;
      DIR_MINUS: delta_x = nstep_x;
      default:   delta_x = '0;
    endcase
    sum_x = lvl_x + delta_x;
    if (sum_x > up_x) begin
      clamp_x = up_x;
    end else if (sum_x < lo_x) begin
      clamp_x = lo_x;
    end else begin
      clamp_x = sum_x;
    end
  end

  assign ticked = state_i.active ? clamp_x[VALUE_WIDTH-1:0] : state_i.level;
  assign tick_x = SW'(ticked);

  // multiplicative damping on the magnitude, truncating toward zero
  assign damp_eff = (cfg_i.damp > DAMP_ONE) ? DAMP_ONE : cfg_i.damp;
  assign mag      = ticked[VALUE_WIDTH-1] ? (~unsigned'(ticked) + 1'b1) : unsigned'(ticked);
  assign prod     = {{DAMP_WIDTH{1'b0}}, mag} * {{VALUE_WIDTH{1'b0}}, damp_eff};
  assign scaled   = prod[DAMP_BITS +: VALUE_WIDTH];
  assign mul_sgn  = ticked[VALUE_WIDTH-1] ? $signed(~scaled + 1'b1) : $signed(scaled);
  assign mul_res  = (mul_sgn == ticked) ? '0 : mul_sgn;

  // linear damping, multiplicative inside one step of zero
  always_comb begin
    lin_x   = '0;
    lin_res = mul_res;
    if (tick_x > step_x) begin
      lin_x   = tick_x - step_x;
      lin_res = (lin_x < step_x) ? '0 : lin_x[VALUE_WIDTH-1:0];
    end else if (tick_x < nstep_x) begin
      lin_x   = tick_x + step_x;
      lin_res = (lin_x > nstep_x) ? '0 : lin_x[VALUE_WIDTH-1:0];
    end
  end

  always_comb begin
    if (cfg_i.multiply) begin
      damped = mul_res;
    end else if (cfg_i.linear && !state_i.active) begin
      damped = lin_res;
    end else begin
      damped = ticked;
    end
  end

  // state update per item kind
  always_comb begin
    state_o = state_i;
    case (op_i)
      OP_TICK: begin
        state_o.level = damped;
      end
      OP_LESS: begin
        state_o.less = pressed_i;
        if (pressed_i) begin
          state_o.active = 1'b1;
          state_o.dir    = DIR_MINUS;
        end else if (state_i.more) begin
          state_o.dir = DIR_PLUS;
        end else begin
          state_o.active = 1'b0;
          state_o.dir    = DIR_NONE;
        end
      end
      OP_MORE: begin
        state_o.more = pressed_i;
        if (pressed_i) begin
          state_o.active = 1'b1;
          state_o.dir    = DIR_PLUS;
        end else if (state_i.less) begin
          state_o.dir = DIR_MINUS;
        end else begin
          state_o.active = 1'b0;
          state_o.dir    = DIR_NONE;
        end
      end
      default: begin
        state_o.stop = pressed_i;
        if (pressed_i) begin
          if (state_i.level > 0) begin
            state_o.dir = DIR_MINUS;
          end else if (state_i.level < 0) begin
            state_o.dir = DIR_PLUS;
          end
        end else if (state_i.less && !state_i.more) begin
          state_o.dir = DIR_MINUS;
        end else if (!state_i.less && state_i.more) begin
          state_o.dir = DIR_PLUS;
        end
      end
    endcase
  end

endmodule

/* design/rvc_checker.sv */
module rvc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [rvc_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata
);
  import rvc_pkg::*;

  // a stalled result item keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  // active exactly while the more or less button is held
  a_active_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[VALUE_WIDTH] ==
                       (m_axis_tdata[VALUE_WIDTH+1] | m_axis_tdata[VALUE_WIDTH+2])))
    else $error("active flag disagrees with held buttons");

  // with the output side empty the input side never stalls
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // an accepted item shows a result after the input and output registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
    else $error("no result after accepted item");

endmodule

bind ramped_value_controller rvc_checker u_rvc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* bench/ramped_value_controller_tb.sv */
`timescale 1ns / 1ps

module ramped_value_controller_tb;
  import rvc_pkg::*;

  // register indexes of the configuration port
  typedef enum int unsigned {
    REG_DAMP     = 0,
    REG_UPPER    = 1,
    REG_LOWER    = 2,
    REG_STEP     = 3,
    REG_LINEAR   = 4,
    REG_MULTIPLY = 5
  } reg_idx_e;

  typedef struct {
    logic signed [VALUE_WIDTH-1:0] level;
    logic                          active;
    logic                          more;
    logic                          less;
    logic                          stop;
  } jog_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata  = '0;  // [0] pressed
  logic [IN_TUSER_WIDTH-1:0]  s_axis_tuser  = '0;  // [1:0] operation
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  // [31:0] level, [32] is_active, [33] more_held, [34] less_held, [35] stop_held
  logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata;
  logic                       psel    = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite  = 1'b0;
  logic [ADDR_WIDTH-1:0]      paddr   = '0;
  logic [DATA_WIDTH-1:0]      pwdata  = '0;
  logic [DATA_WIDTH-1:0]      prdata;
  logic                       pready;

  ramped_value_controller u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted controller state and register copy
  longint          jog_level;
  dir_e            jog_dir;
  bit              more_down, less_down, stop_down, ramp_on;
  longint unsigned damp_q;
  longint          upper_q, lower_q, step_q;
  bit              linear_q, multiply_q;

  jog_result_t jog_result_q[$];
  jog_result_t want;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned errors      = 0;
  int unsigned items_sent  = 0;
  int unsigned results_seen = 0;
  int unsigned reg_writes  = 0;

  // |v| * damp >> 16 with the sign put back, unchanged value snaps to zero
  function automatic longint damp_product(longint v);
    longint unsigned dmp, mag, r;
    longint          res;
    dmp = (damp_q > longint'(DAMP_ONE)) ? longint'(DAMP_ONE) : damp_q;
    mag = (v < 0) ? -v : v;
    r = (mag >> DAMP_BITS) * dmp
        + (((mag & ((64'd1 << DAMP_BITS) - 1)) * dmp) >> DAMP_BITS);
    res = (v < 0) ? -longint'(r) : longint'(r);
    return (res == v) ? 0 : res;
  endfunction

  // ramp, saturate, clamp, then damp
  function automatic void tick_level();
    longint v, d, vmax, vmin;
    vmax = (longint'(1) << (VALUE_WIDTH - 1)) - 1;
    vmin = -vmax - 1;
    v = jog_level;
    if (ramp_on) begin
      d = 0;
      if (jog_dir == DIR_PLUS) d = step_q;
      else if (jog_dir == DIR_MINUS) d = -step_q;
      v = v + d;
      if (v > vmax) v = vmax;
      else if (v < vmin) v = vmin;
      if (v > upper_q) v = upper_q;
      else if (v < lower_q) v = lower_q;
    end
    if (multiply_q) begin
      v = damp_product(v);
    end else if (linear_q && !ramp_on) begin
      if (v > step_q) begin
        v -= step_q;
        if (v < step_q) v = 0;
      end else if (v < -step_q) begin
        v += step_q;
        if (v > -step_q) v = 0;
      end else begin
        v = damp_product(v);
      end
    end
    jog_level = v;
  endfunction

  // apply one item to the predicted state, return the expected result
  function automatic jog_result_t apply_jog_item(op_e op, logic pressed);
    jog_result_t r;
    case (op)
      OP_TICK: tick_level();
      OP_LESS: begin
        less_down = pressed;
        if (pressed) begin
          ramp_on = 1'b1;
          jog_dir = DIR_MINUS;
        end else if (more_down) begin
          jog_dir = DIR_PLUS;
        end else begin
          ramp_on = 1'b0;
          jog_dir = DIR_NONE;
        end
      end
      OP_MORE: begin
        more_down = pressed;
        if (pressed) begin
          ramp_on = 1'b1;
          jog_dir = DIR_PLUS;
        end else if (less_down) begin
          jog_dir = DIR_MINUS;
        end else begin
          ramp_on = 1'b0;
          jog_dir = DIR_NONE;
        end
      end
      default: begin
        stop_down = pressed;
        if (pressed) begin
          if (jog_level > 0) jog_dir = DIR_MINUS;
          else if (jog_level < 0) jog_dir = DIR_PLUS;
        end else begin
          if (less_down && !more_down) jog_dir = DIR_MINUS;
          else if (!less_down && more_down) jog_dir = DIR_PLUS;
        end
      end
    endcase
    r.level  = VALUE_WIDTH'(jog_level);
    r.active = ramp_on;
    r.more   = more_down;
    r.less   = less_down;
    r.stop   = stop_down;
    return r;
  endfunction

  // offer one item, with random idle cycles before it
  task automatic send_item(input op_e op, input logic pressed);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= IN_TDATA_WIDTH'(pressed);
    do @(posedge clk_i); while (!s_axis_tready);
    jog_result_q.push_back(apply_jog_item(op, pressed));
    items_sent++;
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_item(OP_TICK, 1'($urandom_range(1)));
  endtask

  task automatic send_noise_item();
    send_item(op_e'($urandom_range(3)), 1'($urandom_range(1)));
  endtask

  // stop offering and wait until every result is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (jog_result_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // apb write: setup cycle, then access cycle
  task automatic write_register(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_WIDTH'(int'(idx) << ADDR_LSB);
    pwdata  <= DATA_WIDTH'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DAMP:     damp_q     = value[DAMP_WIDTH-1:0];
      REG_UPPER:    upper_q    = longint'($signed(value[VALUE_WIDTH-1:0]));
      REG_LOWER:    lower_q    = longint'($signed(value[VALUE_WIDTH-1:0]));
      REG_STEP:     step_q     = value[STEP_WIDTH-1:0];
      REG_LINEAR:   linear_q   = value[0];
      REG_MULTIPLY: multiply_q = value[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_cycles != 0) hold_cycles <= hold_cycles - 1;
    m_axis_tready <= (hold_cycles == 0) && ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic check_field(input string what, input logic signed [63:0] want_v,
                             input logic signed [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
      errors++;
    end
  endtask

  // compare each result item with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (jog_result_q.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual level %0d",
                 $time, $signed(m_axis_tdata[VALUE_WIDTH-1:0]));
        errors++;
      end else begin
        want = jog_result_q.pop_front();
        check_field("level", want.level, $signed(m_axis_tdata[VALUE_WIDTH-1:0]));
        check_field("is_active", want.active, m_axis_tdata[VALUE_WIDTH]);
        check_field("more_held", want.more, m_axis_tdata[VALUE_WIDTH+1]);
        check_field("less_held", want.less, m_axis_tdata[VALUE_WIDTH+2]);
        check_field("stop_held", want.stop, m_axis_tdata[VALUE_WIDTH+3]);
      end
    end
  end

  // button logic with the reset settings
  task automatic test_button_events();
    send_item(OP_STOP, 1'b1);   // stop at zero level leaves the ramp alone
    send_item(OP_STOP, 1'b0);
    send_item(OP_MORE, 1'b1);
    send_item(OP_TICK, 1'b0);
    send_item(OP_STOP, 1'b1);   // level above zero, ramp turns toward zero
    send_item(OP_TICK, 1'b1);
    send_item(OP_STOP, 1'b0);   // only more held, ramp back to plus
    send_item(OP_LESS, 1'b1);
    send_item(OP_MORE, 1'b0);
    send_item(OP_LESS, 1'b0);
    send_item(OP_TICK, 1'b0);
    drain();
  endtask

  // damping factor above one and at zero
  task automatic test_damp_extremes();
    write_register(REG_DAMP, 32'h1FFFF);
    send_item(OP_MORE, 1'b1);
    send_item(OP_TICK, 1'b0);
    drain();
    write_register(REG_DAMP, 32'd0);
    send_item(OP_TICK, 1'b0);
    drain();
  endtask

  // add saturation at full range, no damping, then inverted limits
  task automatic test_saturation_and_limits();
    write_register(REG_UPPER, 32'h7FFF_FFFF);
    write_register(REG_LOWER, 32'h8000_0000);
    write_register(REG_STEP, 32'h7FFF_FFFF);
    write_register(REG_MULTIPLY, 32'd0);
    write_register(REG_LINEAR, 32'd0);
    send_ticks(2);
    send_item(OP_LESS, 1'b1);
    send_ticks(3);
    drain();
    write_register(REG_UPPER, 32'hFFFF_0000);
    write_register(REG_LOWER, 32'h0001_0000);
    write_register(REG_STEP, 32'd3277);
    send_ticks(2);
    send_item(OP_LESS, 1'b0);
    send_item(OP_MORE, 1'b0);
    drain();
  endtask

  // pick a full set of register values
  task automatic randomize_settings(input bit extreme);
    logic [31:0] up, lo;
    if (extreme) begin
      write_register(REG_DAMP, $urandom_range(1) ? 32'd0 : 32'(DAMP_ONE));
      write_register(REG_STEP, $urandom_range(1) ? 32'd0 : 32'h7FFF_FFFF);
      up = 32'h7FFF_FFFF;
      lo = 32'h8000_0000;
    end else begin
      case ($urandom_range(4))
        0:       write_register(REG_DAMP, 32'(DAMP_ONE));
        1:       write_register(REG_DAMP, 32'd65537 + $urandom_range(65534));
        2:       write_register(REG_DAMP, $urandom & 32'h1FFFF);
        default: write_register(REG_DAMP, $urandom_range(65535, 60000));
      endcase
      case ($urandom_range(3))
        0:       write_register(REG_STEP, $urandom & 32'h7FFF_FFFF);
        default: write_register(REG_STEP, $urandom_range(20000, 1));
      endcase
      up = 32'($urandom_range(8, 1)) << FRACTION_BITS | 32'($urandom_range(65535));
      lo = -(32'($urandom_range(8, 1)) << FRACTION_BITS | 32'($urandom_range(65535)));
      if ($urandom_range(5) == 0) begin
        up = $urandom;
        lo = $urandom;
      end
    end
    write_register(REG_UPPER, up);
    write_register(REG_LOWER, lo);
    write_register(REG_LINEAR, 32'($urandom_range(1)));
    write_register(REG_MULTIPLY, 32'($urandom_range(2) == 0));
  endtask

  // one press-hold-release run with random extra buttons and ticks
  task automatic send_jog_run();
    op_e btn, other;
    btn   = $urandom_range(1) ? OP_MORE : OP_LESS;
    other = (btn == OP_MORE) ? OP_LESS : OP_MORE;
    send_item(btn, 1'b1);
    send_ticks($urandom_range(12, 1));
    if ($urandom_range(2) == 0) begin
      send_item(OP_STOP, 1'b1);
      send_ticks($urandom_range(6, 1));
      send_item(OP_STOP, 1'b0);
    end
    if ($urandom_range(2) == 0) begin
      send_item(other, 1'b1);
      send_ticks($urandom_range(6));
      if ($urandom_range(1)) begin
        send_item(other, 1'b0);
      end else begin
        send_item(btn, 1'b0);
        send_ticks($urandom_range(4));
        btn = other;
      end
    end
    send_item(btn, 1'b0);
    send_ticks($urandom_range(15));
  endtask

  task automatic run_random_phase(input int unsigned n_items);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(9) < 7) send_jog_run();
      else send_noise_item();
    end
    drain();
  endtask

  // random jog traffic under three idle mixes
  task automatic test_random_traffic();
    for (int m = 0; m < 3; m++) begin
      tx_idle_pct = (m == 0) ? 20 : (m == 1) ? 74 : 0;
      rx_idle_pct = (m == 0) ? 74 : (m == 1) ? 20 : 0;
      for (int p = 0; p < 3; p++) begin
        randomize_settings(p == 0);
        run_random_phase(210);
      end
    end
  endtask

  // long output stall while items keep coming
  task automatic test_output_stall();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_cycles <= 400;
    repeat (40) send_noise_item();
    drain();
  endtask

  initial begin
    damp_q     = DAMP_RESET;
    upper_q    = UPPER_RESET;
    lower_q    = LOWER_RESET;
    step_q     = STEP_RESET;
    linear_q   = 1'b0;
    multiply_q = 1'b1;
    jog_level  = 0;
    jog_dir    = DIR_NONE;
    more_down  = 1'b0;
    less_down  = 1'b0;
    stop_down  = 1'b0;
    ramp_on    = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_button_events();
    test_damp_extremes();
    test_saturation_and_limits();
    test_random_traffic();
    test_output_stall();

    $display("sent %0d items, checked %0d results, %0d register writes",
             items_sent, results_seen, reg_writes);
    $display("covered button events, damping extremes, saturation, inverted limits, "
             , "random jog runs under three idle mixes and a long output stall");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

endmodule
